>>> hw/rtl/feedback_echo_delay_assert.svh
// ----------------------------------------------------------------------------
// feedback echo delay assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_DELAY_ASSERT_SVH
`define FEEDBACK_ECHO_DELAY_ASSERT_SVH

// same-cycle implication
`define FED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg
// shared types, widths and constants of the feedback echo delay
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int DELAY_DEPTH = 65536;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W     = $clog2(DELAY_DEPTH);
  localparam int CNT_W      = $clog2(DELAY_DEPTH + 1);
  localparam int DELAY_W    = 17;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // percent scaling datapath
  localparam int PROD_W      = SAMPLE_BITS + 8;
  localparam int MAG_W       = SAMPLE_BITS + 7;
  localparam int Q_W         = SAMPLE_BITS + 1;
  localparam int SUM_W       = SAMPLE_BITS + 3;
  localparam int RECIP_SHIFT = MAG_W + 8;
  localparam int RECIP_W     = RECIP_SHIFT - 5;
  localparam int ROUND_HALF  = 50;

  // ceil(2^RECIP_SHIFT / 100), exact floor division for MAG_W-bit numerators
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(65536);
  localparam logic [PCT_W-1:0]   FB_RST    = PCT_W'(50);
  localparam logic [PCT_W-1:0]   VOL_RST   = PCT_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_VOLUME   = 2'd2
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_in;
    logic    block_end;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    block_end_out;
  } out_item_t;

  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    logic sgn;
    sgn = v[SUM_W-1];
    if (v[SUM_W-1:SAMPLE_BITS-1] == {(SUM_W-SAMPLE_BITS+1){sgn}}) begin
      return sample_t'(v[SAMPLE_BITS-1:0]);
    end
    return sample_t'({sgn, {(SAMPLE_BITS-1){~sgn}}});
  endfunction

endpackage

>>> hw/rtl/fed_ram.sv
// ----------------------------------------------------------------------------
// fed_ram
// delay line memory, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module fed_ram (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [fed_pkg::ADDR_W-1:0]    raddr_i,
  output fed_pkg::sample_t              rdata_o,
  input  logic                          we_i,
  input  logic [fed_pkg::ADDR_W-1:0]    waddr_i,
  input  fed_pkg::sample_t              wdata_i
);
  import fed_pkg::*;

  sample_t mem [DELAY_DEPTH];
  sample_t rdata_q;

  // read returns the old entry on a same-address write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[raddr_i];
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/fed_scale.sv
// ----------------------------------------------------------------------------
// fed_scale
// two-stage percent scaling: product, then divide by 100 rounding half away
// ----------------------------------------------------------------------------
module fed_scale (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  fed_pkg::sample_t             smp_i,
  input  logic [fed_pkg::PCT_W-1:0]    pct_i,
  output logic signed [fed_pkg::Q_W:0] q_o
);
  import fed_pkg::*;

  logic signed [PROD_W-1:0]     smp_x;
  logic signed [PROD_W-1:0]     pct_x;
  logic signed [PROD_W-1:0]     prod;
  logic [MAG_W-1:0]             mag_d;
  logic [MAG_W-1:0]             mag_q;
  logic                         neg_q;
  logic [MAG_W-1:0]             num;
  logic [MAG_W+RECIP_W-1:0]     rprod;
  logic [Q_W-1:0]               quo;
  logic signed [Q_W:0]          q_d;
  logic signed [Q_W:0]          q_q;

  always_comb begin
    smp_x = PROD_W'(smp_i);
    pct_x = PROD_W'({1'b0, pct_i});
    prod  = smp_x * pct_x;
    mag_d = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
  end

  // divide by reciprocal multiply
  always_comb begin
    num   = mag_q + MAG_W'(ROUND_HALF);
    rprod = (MAG_W+RECIP_W)'(num) * (MAG_W+RECIP_W)'(RECIP_MUL);
    quo   = rprod[RECIP_SHIFT +: Q_W];
    q_d   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= prod[PROD_W-1];
      q_q   <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

>>> hw/rtl/feedback_echo_delay.sv
// ----------------------------------------------------------------------------
// feedback_echo_delay: feedback comb echo on a 16-bit mono sample stream
// samples pass the v1, v2, v3 stages and output register; one sample per cycle unless
// the output stalls; delays of one or two samples wait on the writeback
// reset clears registers at once; no memory clearing pass, unwritten entries read as zero
// ----------------------------------------------------------------------------
`include "feedback_echo_delay_assert.svh"

module feedback_echo_delay (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fed_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fed_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fed_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fed_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fed_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DELAY_DEPTH - 1);

  logic [DELAY_W-1:0] delay_q;
  logic [PCT_W-1:0]   fb_pct_q;
  logic [PCT_W-1:0]   vol_pct_q;

  logic [ADDR_W-1:0]  w_q;
  logic [ADDR_W-1:0]  w_nxt;
  logic [ADDR_W-1:0]  w3_nxt;
  logic               full_q;

  logic [CNT_W-1:0]   interval;
  logic [CNT_W:0]     rd_sum;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_ok;
  logic               hazard;
  logic               advance;
  logic               accept;

  logic               v1_q, v2_q, v3_q;
  sample_t            x1_q, x2_q, x3_q;
  logic               be1_q, be2_q, be3_q;
  logic [ADDR_W-1:0]  w1_q, w2_q, w3_q;
  logic [ADDR_W-1:0]  r1_q;
  logic               ok1_q;

  logic               lw_v_q;
  logic [ADDR_W-1:0]  lw_addr_q;
  sample_t            lw_data_q;

  sample_t            rd_data;
  sample_t            echo;
  logic signed [Q_W:0] q_vol;
  logic signed [Q_W:0] q_fb;
  sample_t            y_sat;
  sample_t            fb_sat;

  logic               out_valid_q;
  out_item_t          out_data_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= DELAY_RST;
      fb_pct_q  <= FB_RST;
      vol_pct_q <= VOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DELAY:    delay_q   <= DELAY_W'(cfg_data_i);
        REG_FEEDBACK: fb_pct_q  <= PCT_W'(cfg_data_i);
        REG_VOLUME:   vol_pct_q <= PCT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // read address, zero or oversized delay means full depth
  always_comb begin
    if (delay_q == '0 || 32'(delay_q) > 32'(DELAY_DEPTH)) begin
      interval = CNT_W'(DELAY_DEPTH);
    end else begin
      interval = CNT_W'(delay_q);
    end
    if ((CNT_W+1)'(w_q) >= (CNT_W+1)'(interval)) begin
      rd_sum = (CNT_W+1)'(w_q) - (CNT_W+1)'(interval);
    end else begin
      rd_sum = (CNT_W+1)'(w_q) + (CNT_W+1)'(DELAY_DEPTH) - (CNT_W+1)'(interval);
    end
    rd_addr = rd_sum[ADDR_W-1:0];
    rd_ok   = full_q || (rd_addr < w_q);
    w_nxt   = (w_q == LAST_ADDR) ? '0 : w_q + 1'b1;
    w3_nxt  = (w3_q == LAST_ADDR) ? '0 : w3_q + 1'b1;
  end

  // entries still in flight in the scaling stages cannot be forwarded
  assign hazard     = (v1_q && (w1_q == rd_addr)) || (v2_q && (w2_q == rd_addr));
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      full_q <= 1'b0;
    end else if (accept) begin
      w_q <= w_nxt;
      if (w_q == LAST_ADDR) begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lw_v_q      <= 1'b0;
    end else if (advance) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
      lw_v_q      <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q       <= in_data_i.sample_in;
      be1_q      <= in_data_i.block_end;
      w1_q       <= w_q;
      r1_q       <= rd_addr;
      ok1_q      <= rd_ok;
      x2_q       <= x1_q;
      be2_q      <= be1_q;
      w2_q       <= w1_q;
      x3_q       <= x2_q;
      be3_q      <= be2_q;
      w3_q       <= w2_q;
      lw_addr_q  <= w3_q;
      lw_data_q  <= fb_sat;
      out_data_q <= '{sample_out: y_sat, block_end_out: be3_q};
    end
  end

  fed_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (advance),
    .raddr_i (rd_addr),
    .rdata_o (rd_data),
    .we_i    (v3_q),
    .waddr_i (w3_q),
    .wdata_i (fb_sat)
  );

  // forward the write that landed with the read
  always_comb begin
    if (lw_v_q && (lw_addr_q == r1_q)) begin
      echo = lw_data_q;
    end else if (ok1_q) begin
      echo = rd_data;
    end else begin
      echo = '0;
    end
  end

  fed_scale u_scale_vol (
    .clk_i (clk_i),
    .en_i  (advance),
    .smp_i (echo),
    .pct_i (vol_pct_q),
    .q_o   (q_vol)
  );

  fed_scale u_scale_fb (
    .clk_i (clk_i),
    .en_i  (advance),
    .smp_i (echo),
    .pct_i (fb_pct_q),
    .q_o   (q_fb)
  );

  assign y_sat  = sat_sample(SUM_W'(x3_q) + SUM_W'(q_vol));
  assign fb_sat = sat_sample(SUM_W'(x3_q) + SUM_W'(q_fb));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `FED_ASSERT_IMP(a_no_pending_write, v1_q, !(v2_q && (w2_q == r1_q)) && !(v3_q && (w3_q == r1_q)), "read overlaps a pending write")
  `FED_ASSERT_IMP(a_write_order, v2_q && v3_q, w2_q == w3_nxt, "write positions out of order")
  `FED_ASSERT_NXT(a_index_step, accept, w_q == $past(w_nxt), "write index did not advance")

endmodule
